// ===== sv/gray_histogram_with_extremes_defines.svh =====
// Assertion macros for the gray histogram block.
// Used by the port checker; needs nothing else.
`ifndef GRAY_HISTOGRAM_WITH_EXTREMES_DEFINES_SVH
`define GRAY_HISTOGRAM_WITH_EXTREMES_DEFINES_SVH

// Same-cycle implication.
`define GHE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GHE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ghe_pkg.sv =====
// Shared constants, codes and status types for the gray histogram block.
// No dependencies.
`default_nettype none

package ghe_pkg;

   localparam int BIN_COUNT_DEF  = 256;
   localparam int PIXELS_MAX_DEF = 1048576;
   localparam int PIXEL_W        = 8;
   localparam int COUNT_W        = 21;

   // operation codes
   localparam logic OP_COUNT = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // result kinds
   localparam logic KIND_STATS = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // status of the count stage toward the control logic
   typedef struct packed {
      logic occupied;    // a word sits in the stage
      logic read_out;    // a read word leaves the stage toward the output this cycle
      logic frame_last;  // the frame's last pixel is written back this cycle
      logic can_take;    // the stage can take a new word at this edge
   } stage_status_type;

   // scan accumulator control
   typedef struct packed {
      logic valid;       // read data from the scan is on the RAM output
      logic first;       // that data belongs to bin zero
   } scan_ctl_type;

endpackage

`default_nettype wire

// ===== sv/ghe_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module ghe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/ghe_count.sv =====
// Count stage: read-modify-write of one bin per word, with forwarding of the
// previous write and saturation. Depends on ghe_pkg.
`default_nettype none

module ghe_count #(
   parameter int IDX_W      = 8,
   parameter int CNT_W      = 21,
   parameter int PIXELS_MAX = 1048576
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [IDX_W-1:0]            acc_idx,
   input  wire logic                        acc_op,
   input  wire logic                        acc_last,
   input  wire logic                        out_free,
   input  wire logic [CNT_W-1:0]            rd_data,
   output ghe_pkg::stage_status_type        status,
   output logic                             wr_en,
   output logic      [IDX_W-1:0]            wr_addr,
   output logic      [CNT_W-1:0]            wr_data,
   output logic      [CNT_W-1:0]            cur_count
);

   import ghe_pkg::*;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_op_ff;
   logic             s1_last_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic             fwd_valid_ff;
   logic [IDX_W-1:0] fwd_idx_ff;
   logic [CNT_W-1:0] fwd_data_ff;
   logic             is_pixel;
   logic             advance;

   // the RAM output misses the write made at the edge this word entered
   assign cur_count = (fwd_valid_ff && (fwd_idx_ff == s1_idx_ff)) ? fwd_data_ff : rd_data;

   assign is_pixel = s1_valid_ff && (s1_op_ff == OP_COUNT);
   assign advance  = s1_valid_ff && ((s1_op_ff == OP_COUNT) || out_free);

   assign wr_en   = is_pixel;
   assign wr_addr = s1_idx_ff;
   assign wr_data = (32'(cur_count) < PIXELS_MAX) ? cur_count + 1'b1 : cur_count;

   always_comb begin
      status.occupied   = s1_valid_ff;
      status.read_out   = s1_valid_ff && (s1_op_ff == OP_READ) && out_free;
      status.frame_last = is_pixel && s1_last_ff;
      status.can_take   = !s1_valid_ff
                       || ((s1_op_ff == OP_READ) && out_free)
                       || ((s1_op_ff == OP_COUNT) && !s1_last_ff);
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            fwd_valid_ff <= wr_en;
         end
      end
   end

   // payload: load on accept, hold while the word waits
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= acc_op;
         s1_last_ff  <= acc_last;
         s1_idx_ff   <= acc_idx;
         fwd_idx_ff  <= s1_idx_ff;
         fwd_data_ff <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ghe_scan.sv =====
// Scan accumulator: smallest and largest bin count over one pass of the RAM.
// Depends on ghe_pkg.
`default_nettype none

module ghe_scan #(
   parameter int CNT_W = 21
) (
   input  wire logic                 clock,
   input  wire ghe_pkg::scan_ctl_type ctl,
   input  wire logic [CNT_W-1:0]     rd_data,
   output logic      [CNT_W-1:0]     least,
   output logic      [CNT_W-1:0]     greatest
);

   import ghe_pkg::*;

   logic [CNT_W-1:0] least_ff, least_in;
   logic [CNT_W-1:0] greatest_ff, greatest_in;

   always_comb begin
      least_in    = least_ff;
      greatest_in = greatest_ff;
      if (ctl.valid) begin
         if (ctl.first || (rd_data < least_ff)) begin
            least_in = rd_data;
         end
         if (ctl.first || (rd_data > greatest_ff)) begin
            greatest_in = rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      least_ff    <= least_in;
      greatest_ff <= greatest_in;
   end

   assign least    = least_ff;
   assign greatest = greatest_ff;

endmodule

`default_nettype wire

// ===== sv/gray_histogram_with_extremes.sv =====
// Gray-level histogram with value extremes. Pixels of a frame are counted into
// BIN_COUNT bins held in one synchronous RAM; each pixel is a read-modify-write
// of its bin with forwarding, so an open frame takes one word per cycle. Bin
// reads also take one word per cycle while the result side keeps up. The first
// pixel of a frame waits while a clearing pass zeroes the RAM, and the word that
// ends a frame is followed by a scan (one RAM read per bin) before the
// statistics word is offered and the next word is taken. After reset the same
// clearing pass runs with req_stall high. Counts saturate at PIXELS_MAX; pixel
// values at or above BIN_COUNT count into the last bin.
// Depends on ghe_pkg, ghe_ram, ghe_count, ghe_scan.
`default_nettype none

module gray_histogram_with_extremes #(
   parameter int BIN_COUNT  = ghe_pkg::BIN_COUNT_DEF,
   parameter int PIXELS_MAX = ghe_pkg::PIXELS_MAX_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_operation,
   input  wire logic [ghe_pkg::PIXEL_W-1:0]   req_pixel_or_bin,
   input  wire logic                          req_frame_end,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_result_kind,
   output logic      [ghe_pkg::PIXEL_W-1:0]   rsp_low_value,
   output logic      [ghe_pkg::PIXEL_W-1:0]   rsp_high_value,
   output logic      [ghe_pkg::COUNT_W-1:0]   rsp_least_count,
   output logic      [ghe_pkg::COUNT_W-1:0]   rsp_greatest_count,
   output logic      [ghe_pkg::COUNT_W-1:0]   rsp_bin_count
);

   import ghe_pkg::*;

   localparam int IDX_W = $clog2(BIN_COUNT);
   localparam int CNT_W = $clog2(PIXELS_MAX + 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RUN,
      ST_SCAN,
      ST_TAIL,
      ST_EMIT
   } state_type;

   state_type          state_ff;
   logic [IDX_W-1:0]   walk_addr_ff;
   logic               open_after_ff;
   logic               frame_open_ff;
   logic [PIXEL_W-1:0] run_low_ff;
   logic [PIXEL_W-1:0] run_high_ff;
   scan_ctl_type       scan_ctl_ff;
   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   logic [PIXEL_W-1:0] rsp_low_ff;
   logic [PIXEL_W-1:0] rsp_high_ff;
   logic [COUNT_W-1:0] rsp_least_ff;
   logic [COUNT_W-1:0] rsp_greatest_ff;
   logic [COUNT_W-1:0] rsp_bin_ff;

   stage_status_type   st;
   logic [IDX_W-1:0]   req_idx;
   logic               req_is_count;
   logic               out_free;
   logic               accept;
   logic               start_clear;
   logic               walk_last;
   logic               scan_issue;
   logic               emit_load;
   logic               cnt_wr_en;
   logic [IDX_W-1:0]   cnt_wr_addr;
   logic [CNT_W-1:0]   cnt_wr_data;
   logic [CNT_W-1:0]   cur_count;
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [CNT_W-1:0]   ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [CNT_W-1:0]   ram_rd_data;
   logic [CNT_W-1:0]   scan_least;
   logic [CNT_W-1:0]   scan_greatest;

   // clamp out-of-range values to the last bin
   always_comb begin
      if (32'(req_pixel_or_bin) >= BIN_COUNT) begin
         req_idx = IDX_W'(BIN_COUNT - 1);
      end else begin
         req_idx = IDX_W'(req_pixel_or_bin);
      end
   end

   assign req_is_count = (req_operation == OP_COUNT);
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = (state_ff != ST_RUN) || !st.can_take
                      || (req_is_count && !frame_open_ff);
   assign accept       = req_valid && !req_stall;
   assign start_clear  = (state_ff == ST_RUN) && req_valid && req_is_count
                      && !frame_open_ff && !st.occupied;
   assign walk_last    = (walk_addr_ff == IDX_W'(BIN_COUNT - 1));
   assign scan_issue   = (state_ff == ST_SCAN);
   assign emit_load    = (state_ff == ST_EMIT) && out_free;

   assign ram_rd_en   = accept || scan_issue;
   assign ram_rd_addr = scan_issue ? walk_addr_ff : req_idx;
   assign ram_wr_en   = (state_ff == ST_CLEAR) || cnt_wr_en;
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? walk_addr_ff : cnt_wr_addr;
   assign ram_wr_data = (state_ff == ST_CLEAR) ? '0 : cnt_wr_data;

   ghe_ram #(
      .WIDTH (CNT_W),
      .DEPTH (BIN_COUNT)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ghe_count #(
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .PIXELS_MAX (PIXELS_MAX)
   ) u_count (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .acc_idx   (req_idx),
      .acc_op    (req_operation),
      .acc_last  (req_frame_end),
      .out_free  (out_free),
      .rd_data   (ram_rd_data),
      .status    (st),
      .wr_en     (cnt_wr_en),
      .wr_addr   (cnt_wr_addr),
      .wr_data   (cnt_wr_data),
      .cur_count (cur_count)
   );

   ghe_scan #(
      .CNT_W (CNT_W)
   ) u_scan (
      .clock    (clock),
      .ctl      (scan_ctl_ff),
      .rd_data  (ram_rd_data),
      .least    (scan_least),
      .greatest (scan_greatest)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_CLEAR;
         walk_addr_ff      <= '0;
         open_after_ff     <= 1'b0;
         frame_open_ff     <= 1'b0;
         run_low_ff        <= '1;
         run_high_ff       <= '0;
         scan_ctl_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         scan_ctl_ff.valid <= scan_issue;
         scan_ctl_ff.first <= scan_issue && (walk_addr_ff == '0);

         case (state_ff)
            ST_CLEAR: begin
               if (walk_last) begin
                  walk_addr_ff  <= '0;
                  frame_open_ff <= open_after_ff;
                  run_low_ff    <= '1;
                  run_high_ff   <= '0;
                  state_ff      <= ST_RUN;
               end else begin
                  walk_addr_ff <= walk_addr_ff + 1'b1;
               end
            end
            ST_RUN: begin
               if (start_clear) begin
                  open_after_ff <= 1'b1;
                  walk_addr_ff  <= '0;
                  state_ff      <= ST_CLEAR;
               end else if (st.frame_last) begin
                  walk_addr_ff <= '0;
                  state_ff     <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (walk_last) begin
                  walk_addr_ff <= '0;
                  state_ff     <= ST_TAIL;
               end else begin
                  walk_addr_ff <= walk_addr_ff + 1'b1;
               end
            end
            ST_TAIL: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  frame_open_ff <= 1'b0;
                  state_ff      <= ST_RUN;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase

         if (accept && req_is_count) begin
            if (req_pixel_or_bin < run_low_ff) begin
               run_low_ff <= req_pixel_or_bin;
            end
            if (req_pixel_or_bin > run_high_ff) begin
               run_high_ff <= req_pixel_or_bin;
            end
         end

         if (st.read_out || emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // result payload; hold while stalled since loads need out_free
      if (st.read_out) begin
         rsp_kind_ff     <= KIND_READ;
         rsp_low_ff      <= '0;
         rsp_high_ff     <= '0;
         rsp_least_ff    <= '0;
         rsp_greatest_ff <= '0;
         rsp_bin_ff      <= COUNT_W'(cur_count);
      end else if (emit_load) begin
         rsp_kind_ff     <= KIND_STATS;
         rsp_low_ff      <= run_low_ff;
         rsp_high_ff     <= run_high_ff;
         rsp_least_ff    <= COUNT_W'(scan_least);
         rsp_greatest_ff <= COUNT_W'(scan_greatest);
         rsp_bin_ff      <= '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_low_value      = rsp_low_ff;
   assign rsp_high_value     = rsp_high_ff;
   assign rsp_least_count    = rsp_least_ff;
   assign rsp_greatest_count = rsp_greatest_ff;
   assign rsp_bin_count      = rsp_bin_ff;

endmodule

`default_nettype wire

// ===== sv/ghe_checker.sv =====
// Port-level checker for the gray histogram block, bound to the top level.
// Depends on ghe_pkg and the assertion macro header.
`default_nettype none
`include "gray_histogram_with_extremes_defines.svh"

module ghe_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic                        req_operation,
   input wire logic [ghe_pkg::PIXEL_W-1:0] req_pixel_or_bin,
   input wire logic                        req_frame_end,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic                        rsp_result_kind,
   input wire logic [ghe_pkg::PIXEL_W-1:0] rsp_low_value,
   input wire logic [ghe_pkg::PIXEL_W-1:0] rsp_high_value,
   input wire logic [ghe_pkg::COUNT_W-1:0] rsp_least_count,
   input wire logic [ghe_pkg::COUNT_W-1:0] rsp_greatest_count,
   input wire logic [ghe_pkg::COUNT_W-1:0] rsp_bin_count
);

   import ghe_pkg::*;

   logic stats_word;
   logic read_word;
   logic last_pixel_taken;

   assign stats_word = rsp_valid && (rsp_result_kind == KIND_STATS);
   assign read_word  = rsp_valid && (rsp_result_kind == KIND_READ);
   assign last_pixel_taken = req_valid && !req_stall && (req_operation == OP_COUNT)
                          && req_frame_end && (req_pixel_or_bin == req_pixel_or_bin);

   // a statistics word covers at least one pixel
   `GHE_ASSERT_NOW(a_stats_shape, clock, reset, stats_word, (rsp_bin_count == '0) && (rsp_low_value <= rsp_high_value) && (rsp_least_count <= rsp_greatest_count), "statistics word malformed")

   `GHE_ASSERT_NOW(a_read_shape, clock, reset, read_word, (rsp_low_value == '0) && (rsp_high_value == '0) && (rsp_least_count == '0) && (rsp_greatest_count == '0), "read word carries statistics")

   // the bin scan holds off new words after a frame ends
   `GHE_ASSERT_NEXT(a_scan_stall, clock, reset, last_pixel_taken, req_stall, "word taken during bin scan")

   `GHE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_kind) && $stable(rsp_bin_count) && $stable(rsp_least_count) && $stable(rsp_greatest_count), "stalled result changed")

   `GHE_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && req_stall, "result or intake active out of reset")

endmodule

bind gray_histogram_with_extremes ghe_checker u_ghe_checker (.*);

`default_nettype wire
